FILE: hw/rtl/newton_interpolation_engine_unit_defines.svh
// assertion macros for the newton interpolation engine
`ifndef NEWTON_INTERPOLATION_ENGINE_UNIT_DEFINES_SVH
`define NEWTON_INTERPOLATION_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NIE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("nie assertion failed");
`define NIE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("nie forbidden condition");
`else
`define NIE_ASSERT(lbl, clk, rst_n, prop)
`define NIE_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: hw/rtl/nie_pkg.sv
// types, codes and helpers shared by the newton interpolation engine
package nie_pkg;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_EVAL  = 2'd2;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FULL   = 3'd1;
	localparam logic [2:0] ST_EMPTY  = 3'd2;
	localparam logic [2:0] ST_REPEAT = 3'd3;
	localparam logic [2:0] ST_SAT    = 3'd4;

	localparam logic signed [63:0] WIDE_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] point_x;
		logic signed [31:0] node_value;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [2:0]         status;
	} out_t;

	typedef struct packed {
		logic               done;
		logic               sat;
		logic signed [63:0] value;
	} mul_rsp_t;

	typedef struct packed {
		logic               done;
		logic               sat;
		logic signed [31:0] value;
	} div_rsp_t;

	typedef struct packed {
		logic               sat;
		logic signed [63:0] value;
	} wide_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DEN_RD, S_DEN_GO, S_DEN_WT, S_EV_RD, S_EV_CGO, S_EV_CWT,
		S_EV_PGO, S_EV_PWT, S_POST, S_DIV_GO, S_DIV_WT, S_FIN
	} state_t;

	function automatic wide_t wide_clamp(input logic signed [63:0] v);
		wide_t r;
		r.sat = 1'b0;
		r.value = v;
		if (v > WIDE_MAX) begin
			r.sat = 1'b1;
			r.value = WIDE_MAX;
		end else if (v < -WIDE_MAX) begin
			r.sat = 1'b1;
			r.value = -WIDE_MAX;
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/nie_ram.sv
// generic single-write ram with registered read
module nie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hw/rtl/nie_mul.sv
// iterative fixed-point multiplier: four 32x32 partial products, saturating
module nie_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output nie_pkg::mul_rsp_t  rsp
);
	import nie_pkg::*;

	logic               busy_q;
	logic [2:0]         step_q;
	logic [63:0]        ua_q, ub_q;
	logic               neg_q;
	logic [63:0]        pp_q;
	logic [1:0]         sh_q;
	logic [127:0]       acc_q;
	logic [31:0]        ma, mb;
	logic [63:0]        pp_c;
	logic [127:0]       full;
	logic               sat_c;
	logic [63:0]        mag_c;
	logic               done_q;
	logic               rsat_q;
	logic signed [63:0] rval_q;

	assign ma = step_q[0] ? ua_q[63:32] : ua_q[31:0];
	assign mb = step_q[1] ? ub_q[63:32] : ub_q[31:0];
	assign pp_c = ma * mb;

	assign full = acc_q >> FRAC_BITS;
	assign sat_c = |full[127:62];
	assign mag_c = sat_c ? WIDE_MAX : {2'b00, full[61:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (step_q == 3'd5);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == 3'd5) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			step_q <= 3'd0;
			ua_q <= a[63] ? 64'(-a) : 64'(a);
			ub_q <= b[63] ? 64'(-b) : 64'(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q < 3'd4) begin
				pp_q <= pp_c;
				sh_q <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
			end
			if (step_q >= 3'd1 && step_q <= 3'd4) begin
				acc_q <= acc_q + ({64'b0, pp_q} << {sh_q, 5'b0});
			end
			if (step_q == 3'd5) begin
				rsat_q <= sat_c;
				rval_q <= neg_q ? -$signed(mag_c) : $signed(mag_c);
			end
		end
	end

	assign rsp = '{done: done_q, sat: rsat_q, value: rval_q};
endmodule

FILE: hw/rtl/nie_div.sv
// bit-serial restoring divider: sign * floor(|num| * 2^frac / |den|), clamped to 32 bits
module nie_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [63:0] den,
	output nie_pkg::div_rsp_t  rsp
);
	import nie_pkg::*;

	localparam int NB  = 64 + FRAC_BITS;
	localparam int CNW = $clog2(NB + 1);

	logic               busy_q;
	logic [CNW-1:0]     cnt_q;
	logic [NB-1:0]      sh_q;
	logic [63:0]        ud_q, rem_q;
	logic [32:0]        q_q;
	logic               big_q, neg_q;
	logic [63:0]        rem_n;
	logic               ge;
	logic [32:0]        qn;
	logic               fin;
	logic               done_q;
	logic               rsat_q;
	logic signed [31:0] rval_q;

	assign rem_n = {rem_q[62:0], sh_q[NB-1]};
	assign ge = rem_n >= ud_q;
	assign qn = {q_q[31:0], ge};
	assign fin = busy_q && (cnt_q == CNW'(NB));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
			if (start) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q <= '0;
			sh_q <= {(num[63] ? 64'(-num) : 64'(num)), {FRAC_BITS{1'b0}}};
			ud_q <= den[63] ? 64'(-den) : 64'(den);
			rem_q <= '0;
			q_q <= '0;
			big_q <= 1'b0;
			neg_q <= num[63] ^ den[63];
		end else if (busy_q && !fin) begin
			cnt_q <= cnt_q + CNW'(1);
			sh_q <= {sh_q[NB-2:0], 1'b0};
			rem_q <= ge ? rem_n - ud_q : rem_n;
			if (!big_q) begin
				q_q <= qn;
				big_q <= qn[32];
			end
		end else if (fin) begin
			if (neg_q) begin
				if (big_q || q_q > 33'h0_8000_0000) begin
					rsat_q <= 1'b1;
					rval_q <= 32'sh8000_0000;
				end else begin
					rsat_q <= 1'b0;
					rval_q <= -$signed(q_q[31:0]);
				end
			end else begin
				if (big_q || q_q > 33'h0_7FFF_FFFF) begin
					rsat_q <= 1'b1;
					rval_q <= 32'sh7FFF_FFFF;
				end else begin
					rsat_q <= 1'b0;
					rval_q <= $signed(q_q[31:0]);
				end
			end
		end
	end

	assign rsp = '{done: done_q, sat: rsat_q, value: rval_q};
endmodule

FILE: hw/rtl/newton_interpolation_engine_unit.sv
// Newton-form interpolation engine, signed fixed point, node table of MAX_NODES entries
//
// Input channel (in_valid/in_ready/in_data) takes one command beat: clear, add node
// (point_x, node_value) or evaluate at point_x. Output channel (out_valid/out_ready/
// out_data) returns exactly one beat per command: result_value and status.
// One command is in work at a time; in_ready is high only while the sequencer idles.
// Clear, full, empty and unknown commands go straight from the idle state to the finish
// state. Evaluate walks the stored nodes through the polynomial; add with stored nodes
// first walks the denominator, then the polynomial, then runs the divider and
// finishes (the first node goes straight to the divider).
// Every product goes through the one shared multiplier (four 32x32 partial products),
// which sets the per-node cost; the quotient comes from a one-bit-a-cycle divider.
// The result sits in an output register: the next command is accepted while it
// waits, and if the receiver stalls, the finished command holds until the register
// frees. Reset empties the table (node count zero) and drops any pending beat;
// the table storage itself needs no clearing.
`include "newton_interpolation_engine_unit_defines.svh"
module newton_interpolation_engine_unit #(
	parameter int MAX_NODES = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  nie_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output nie_pkg::out_t out_data
);
	import nie_pkg::*;

	localparam int IW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

	state_t             state_q, state_n;
	logic [1:0]         cmd_q;
	logic signed [31:0] x_q, y_q;
	logic [IW-1:0]      idx_q;
	logic [CW-1:0]      count_q;
	logic signed [63:0] den_q, prod_q, acc_q;
	logic               sat_q;
	logic signed [31:0] val_q;
	logic [2:0]         st_q;
	logic               out_valid_q;
	out_t               out_q;

	logic               accept, last, out_free;
	logic [31:0]        pos_rd, coef_rd;
	logic signed [63:0] diff;
	logic               mul_start, div_start, ram_we;
	logic signed [63:0] mul_a, mul_b;
	mul_rsp_t           mrsp;
	div_rsp_t           drsp;
	wide_t              acc_add, num_c;
	logic               c32_sat;
	logic signed [31:0] c32_val;

	assign accept = in_valid && in_ready;
	assign last = (CW'(idx_q) + CW'(1)) == count_q;
	assign out_free = !out_valid_q || out_ready;
	assign diff = {{32{x_q[31]}}, x_q} - {{32{pos_rd[31]}}, pos_rd};
	assign acc_add = wide_clamp(acc_q + mrsp.value);
	assign num_c = wide_clamp({{32{y_q[31]}}, y_q} - acc_q);

	always_comb begin
		c32_sat = 1'b0;
		c32_val = acc_q[31:0];
		if (acc_q > 64'sh7FFF_FFFF) begin
			c32_sat = 1'b1;
			c32_val = 32'sh7FFF_FFFF;
		end else if (acc_q < -64'sh8000_0000) begin
			c32_sat = 1'b1;
			c32_val = 32'sh8000_0000;
		end
	end

	nie_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_pos_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IW-1:0]),
		.wdata (x_q),
		.raddr (idx_q),
		.rdata (pos_rd)
	);

	nie_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_coef_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IW-1:0]),
		.wdata (drsp.value),
		.raddr (idx_q),
		.rdata (coef_rd)
	);

	nie_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.rsp    (mrsp)
	);

	nie_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_c.value),
		.den    (den_q),
		.rsp    (drsp)
	);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_data.cmd == CMD_ADD) begin
						if (count_q >= CW'(MAX_NODES)) state_n = S_FIN;
						else if (count_q == '0) state_n = S_DIV_GO;
						else state_n = S_DEN_RD;
					end else if (in_data.cmd == CMD_EVAL && count_q != '0) begin
						state_n = S_EV_RD;
					end else begin
						state_n = S_FIN;
					end
				end
			end
			S_DEN_RD: state_n = S_DEN_GO;
			S_DEN_GO: state_n = (diff == '0) ? S_FIN : S_DEN_WT;
			S_DEN_WT: begin
				if (mrsp.done) begin
					if (mrsp.value == '0) state_n = S_FIN;
					else if (last) state_n = S_EV_RD;
					else state_n = S_DEN_RD;
				end
			end
			S_EV_RD:  state_n = S_EV_CGO;
			S_EV_CGO: state_n = S_EV_CWT;
			S_EV_CWT: begin
				if (mrsp.done) state_n = last ? S_POST : S_EV_PGO;
			end
			S_EV_PGO: state_n = S_EV_PWT;
			S_EV_PWT: begin
				if (mrsp.done) state_n = S_EV_RD;
			end
			S_POST:   state_n = (cmd_q == CMD_EVAL) ? S_FIN : S_DIV_GO;
			S_DIV_GO: state_n = S_DIV_WT;
			S_DIV_WT: begin
				if (drsp.done) state_n = S_FIN;
			end
			S_FIN: begin
				if (out_free) state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		in_ready = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		ram_we = 1'b0;
		mul_a = prod_q;
		mul_b = diff;
		unique case (state_q)
			S_IDLE:   in_ready = 1'b1;
			S_DEN_GO: begin
				mul_start = (diff != '0);
				mul_a = den_q;
			end
			S_EV_CGO: begin
				mul_start = 1'b1;
				mul_a = {{32{coef_rd[31]}}, coef_rd};
				mul_b = prod_q;
			end
			S_EV_PGO: mul_start = 1'b1;
			S_DIV_GO: div_start = 1'b1;
			S_DIV_WT: ram_we = drsp.done;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept && in_data.cmd == CMD_CLEAR) begin
				count_q <= '0;
			end else if (ram_we) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q <= in_data.cmd;
				x_q <= in_data.point_x;
				y_q <= in_data.node_value;
				idx_q <= '0;
				den_q <= ONE;
				prod_q <= ONE;
				acc_q <= '0;
				sat_q <= 1'b0;
				val_q <= '0;
				st_q <= ST_OK;
				if (in_data.cmd == CMD_ADD && count_q >= CW'(MAX_NODES)) begin
					st_q <= ST_FULL;
				end else if (in_data.cmd == CMD_EVAL && count_q == '0) begin
					st_q <= ST_EMPTY;
				end
			end
			S_DEN_GO: begin
				if (diff == '0) st_q <= ST_REPEAT;
			end
			S_DEN_WT: begin
				if (mrsp.done) begin
					den_q <= mrsp.value;
					sat_q <= sat_q | mrsp.sat;
					if (mrsp.value == '0) st_q <= ST_REPEAT;
					else if (last) idx_q <= '0;
					else idx_q <= idx_q + IW'(1);
				end
			end
			S_EV_CWT: begin
				if (mrsp.done) begin
					acc_q <= acc_add.value;
					sat_q <= sat_q | mrsp.sat | acc_add.sat;
				end
			end
			S_EV_PWT: begin
				if (mrsp.done) begin
					prod_q <= mrsp.value;
					sat_q <= sat_q | mrsp.sat;
					idx_q <= idx_q + IW'(1);
				end
			end
			S_POST: begin
				if (cmd_q == CMD_EVAL) begin
					val_q <= c32_val;
					st_q <= (sat_q || c32_sat) ? ST_SAT : ST_OK;
				end
			end
			S_DIV_GO: sat_q <= sat_q | num_c.sat;
			S_DIV_WT: begin
				if (drsp.done) begin
					val_q <= drsp.value;
					st_q <= (sat_q || drsp.sat) ? ST_SAT : ST_OK;
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_q.result_value <= val_q;
					out_q.status <= st_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`NIE_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CW'(MAX_NODES))
	`NIE_ASSERT(a_write_room, clk, arst_n, ram_we |-> count_q < CW'(MAX_NODES))
	`NIE_ASSERT(a_accept_busy, clk, arst_n, accept |=> state_q != S_IDLE)
	`NIE_ASSERT_NEVER(a_units_overlap, clk, arst_n, mul_start && div_start)
endmodule

FILE: sim/tb_newton_interpolation_engine_unit.sv
// testbench for the newton interpolation engine: directed and random command beats checked against a predictor
`timescale 1ns / 1ps
module tb_newton_interpolation_engine_unit;
	import nie_pkg::*;

	localparam int NODES = 16;
	localparam int FRAC = 16;
	localparam longint LIMIT = 3_000_000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	newton_interpolation_engine_unit #(.MAX_NODES(NODES), .FRAC_BITS(FRAC)) u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	class newton_scoreboard;
		logic signed [31:0] xs[NODES];
		logic signed [31:0] cs[NODES];
		int count;
		out_t pending[$];
		int errors;

		function longint mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		function longint wclamp(longint v, ref bit sat);
			if (v > WIDE_MAX) begin
				sat = 1;
				return WIDE_MAX;
			end
			if (v < -WIDE_MAX) begin
				sat = 1;
				return -WIDE_MAX;
			end
			return v;
		endfunction

		function longint fxmul(longint a, longint b, ref bit sat);
			logic [127:0] p;
			logic [127:0] r;
			longint m;
			p = 128'(mag(a)) * 128'(mag(b));
			r = p >> FRAC;
			if (r > 128'(WIDE_MAX)) begin
				sat = 1;
				m = WIDE_MAX;
			end else begin
				m = longint'(r[63:0]);
			end
			return ((a < 0) != (b < 0)) ? -m : m;
		endfunction

		function longint poly(longint x, ref bit sat);
			longint acc;
			longint prod;
			acc = 0;
			prod = longint'(1) << FRAC;
			for (int i = 0; i < count; i++) begin
				acc = wclamp(acc + fxmul(longint'(cs[i]), prod, sat), sat);
				if (i + 1 < count) prod = fxmul(prod, x - longint'(xs[i]), sat);
			end
			return acc;
		endfunction

		function longint fxdiv(longint num, longint den, ref bit sat);
			logic [127:0] q;
			bit neg;
			neg = (num < 0) != (den < 0);
			q = (128'(mag(num)) << FRAC) / 128'(mag(den));
			if (neg) begin
				if (q > 128'h8000_0000) begin
					sat = 1;
					return -64'sd2147483648;
				end
				return -longint'(q[63:0]);
			end
			if (q > 128'h7FFF_FFFF) begin
				sat = 1;
				return 64'sd2147483647;
			end
			return longint'(q[63:0]);
		endfunction

		function void note_command(in_t c);
			out_t e;
			longint x;
			longint y;
			longint den;
			longint num;
			longint v;
			bit sat;
			bit dsat;
			bit zero;
			x = longint'(c.point_x);
			y = longint'(c.node_value);
			v = 0;
			sat = 0;
			e.status = ST_OK;
			if (c.cmd == CMD_CLEAR) begin
				count = 0;
			end else if (c.cmd == CMD_ADD) begin
				if (count >= NODES) begin
					e.status = ST_FULL;
				end else begin
					den = longint'(1) << FRAC;
					dsat = 0;
					zero = 0;
					for (int j = 0; j < count && !zero; j++) begin
						if (x == longint'(xs[j])) zero = 1;
						else begin
							den = fxmul(den, x - longint'(xs[j]), dsat);
							if (den == 0) zero = 1;
						end
					end
					if (zero) begin
						e.status = ST_REPEAT;
					end else begin
						sat = dsat;
						num = wclamp(y - poly(x, sat), sat);
						v = fxdiv(num, den, sat);
						xs[count] = c.point_x;
						cs[count] = v[31:0];
						count++;
						if (sat) e.status = ST_SAT;
					end
				end
			end else if (c.cmd == CMD_EVAL) begin
				if (count == 0) begin
					e.status = ST_EMPTY;
				end else begin
					v = poly(x, sat);
					if (v > 64'sd2147483647) begin
						sat = 1;
						v = 64'sd2147483647;
					end else if (v < -64'sd2147483648) begin
						sat = 1;
						v = -64'sd2147483648;
					end
					if (sat) e.status = ST_SAT;
				end
			end
			e.result_value = v[31:0];
			pending.insert(pending.size(), e);
		endfunction

		function void check_result(out_t got);
			out_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.result_value !== e.result_value)
				$display("%0t: result_value expected %h actual %h", $time, e.result_value,
					got.result_value);
			if (got.status !== e.status)
				$display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
			if (got.result_value !== e.result_value || got.status !== e.status) errors++;
		endfunction
	endclass

	newton_scoreboard sb;
	int send_idle;
	int recv_stall;
	longint cycles;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		sb = new();
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		send_idle = 0;
		recv_stall = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	// accepted beats on both sides
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_command(in_data);
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	always @(posedge clk) begin
		cycles++;
		if (arst_n) out_ready <= ($urandom_range(99) >= recv_stall);
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// valid stays up between beats sent back to back
	task automatic send(logic [1:0] c, logic signed [31:0] x, logic signed [31:0] y);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{cmd: c, point_x: x, node_value: y};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_x();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
		endcase
	endfunction

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		int n;
		int phase;
		@(posedge arst_n);
		@(posedge clk);
		// directed: empty table, extremes, repeated node, overflowing table, unknown command
		send(CMD_EVAL, 0, 0);
		send(CMD_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send(CMD_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send(CMD_EVAL, 32'sh7FFF_FFFF, 0);
		send(CMD_EVAL, 32'sh8000_0000, 0);
		send(CMD_ADD, 32'sh7FFF_FFFF, 5);
		send(CMD_ADD, 32'sh0000_0001, 5);
		send(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		for (int i = 0; i < 17; i++) send(CMD_ADD, i << 16, (i * i) << 16);
		send(CMD_EVAL, 32'sh0002_8000, 0);
		send(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(CMD_CLEAR, 0, 0);
		drain();
		for (phase = 0; phase < 4; phase++) begin
			send_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 54 : 36) : 0;
			recv_stall = (phase == 2) ? 54 : (phase == 3 ? 36 : 0);
			n = 0;
			while (n < 275) begin
				int len;
				len = $urandom_range(1, 17);
				send(CMD_CLEAR, rand_x(), $urandom());
				n++;
				for (int k = 0; k < len; k++) begin
					send(CMD_ADD, rand_x(), $urandom_range(9) == 0 ? 32'($urandom()) : rand_x());
					n++;
					if ($urandom_range(2) == 0) begin
						send(CMD_EVAL, rand_x(), $urandom());
						n++;
					end
				end
				if ($urandom_range(9) == 0) begin
					send(CMD_UNUSED, $urandom(), $urandom());
					n++;
				end
			end
			drain();
		end
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/nie_pkg.sv
hw/rtl/nie_ram.sv
hw/rtl/nie_mul.sv
hw/rtl/nie_div.sv
hw/rtl/newton_interpolation_engine_unit.sv
sim/tb_newton_interpolation_engine_unit.sv
